>>> design/delimited_frame_receiver_defines.svh
// Assertion macros for the port-level checker of the delimited frame receiver.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef DELIMITED_FRAME_RECEIVER_DEFINES_SVH
`define DELIMITED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("delimited_frame_receiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("delimited_frame_receiver: next-cycle check failed");

// Next-cycle implication that is also checked through reset.
`define DFR_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("delimited_frame_receiver: reset check failed");

`endif

>>> design/dfr_pkg.sv
// Shared types and constants of the delimited frame receiver.
// Depends on nothing; used by every design module but dfr_checker, and by the testbench.
package dfr_pkg;

    // Width of one serial byte and of the configuration data bus.
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 32;

    // Reset values of the delimiter registers ('<' and '>').
    localparam logic [BYTE_W-1:0] DEF_START_DELIM = 8'h3C;
    localparam logic [BYTE_W-1:0] DEF_END_DELIM   = 8'h3E;

    // Register indexes on the configuration port.
    typedef enum logic {
        REG_START_DELIM = 1'b0,
        REG_END_DELIM   = 1'b1
    } t_reg_idx;

    // Delimiter settings handed from the register file to the controller.
    typedef struct packed {
        logic [BYTE_W-1:0] start_d;
        logic [BYTE_W-1:0] end_d;
    } t_delims;

endpackage

>>> design/dfr_store.sv
// Frame store: simple dual-port memory with registered read.
// Depends on dfr_pkg for the byte width.
module dfr_store
    import dfr_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/dfr_ctrl.sv
// Frame controller: delimiter detection, store write-back and frame readout.
// Depends on dfr_pkg; drives the dfr_store memory ports.
module dfr_ctrl
    import dfr_pkg::*;
#(
    parameter int FRAME_LEN = 16,
    parameter int CW        = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_delims           i_delims,
    // Received byte stream.
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    // Frame byte stream.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_last,
    // Memory ports.
    output logic              o_mem_we,
    output logic [CW-1:0]     o_mem_waddr,
    output logic [BYTE_W-1:0] o_mem_wdata,
    output logic              o_mem_re,
    output logic [CW-1:0]     o_mem_raddr,
    input  logic [BYTE_W-1:0] i_mem_rdata
);

    typedef enum logic [1:0] {
        ST_RECV  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    localparam logic [CW-1:0] FULL_IDX = CW'(FRAME_LEN - 2);

    t_state            r_state, n_state;
    logic              r_in_frame, n_in_frame;
    logic [CW-1:0]     r_fill, n_fill;
    logic [CW-1:0]     r_rd_idx, n_rd_idx;
    logic [CW-1:0]     r_last_idx, n_last_idx;
    logic              r_rd_vld, n_rd_vld;
    logic              r_rd_last, n_rd_last;
    logic              r_out_vld, n_out_vld;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic accept;
    logic is_start;
    logic is_end;
    logic move;
    logic issue;

    assign o_in_ready = (r_state == ST_RECV);
    assign accept     = i_in_valid && o_in_ready;
    assign is_start   = (i_in_byte == i_delims.start_d);
    assign is_end     = (i_in_byte == i_delims.end_d);

    // Readout pipeline: the memory read register feeds the output register.
    assign move  = r_rd_vld && (!r_out_vld || i_out_ready);
    assign issue = (r_state == ST_DRAIN) && (!r_rd_vld || move);

    assign o_mem_wdata = i_in_byte;
    assign o_mem_re    = issue;
    assign o_mem_raddr = r_rd_idx;

    // Byte classification and write-back into the frame store.
    always_comb begin
        n_state     = r_state;
        n_in_frame  = r_in_frame;
        n_fill      = r_fill;
        n_rd_idx    = r_rd_idx;
        n_last_idx  = r_last_idx;
        n_rd_vld    = r_rd_vld;
        n_rd_last   = r_rd_last;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_fill;

        if (accept) begin
            if (is_start) begin
                // A start delimiter always opens a fresh frame at entry zero.
                o_mem_we    = 1'b1;
                o_mem_waddr = '0;
                n_fill      = CW'(1);
                n_in_frame  = 1'b1;
            end else if (!r_in_frame) begin
                // Idle: the byte is discarded.
            end else if (r_fill == FULL_IDX && !is_end) begin
                // Frame overflow: drop the byte and go idle.
                n_fill     = '0;
                n_in_frame = 1'b0;
            end else if (is_end) begin
                // Closing delimiter: store it and start the readout.
                o_mem_we   = 1'b1;
                n_last_idx = r_fill;
                n_rd_idx   = '0;
                n_fill     = '0;
                n_in_frame = 1'b0;
                n_state    = ST_DRAIN;
            end else begin
                o_mem_we = 1'b1;
                n_fill   = r_fill + CW'(1);
            end
        end

        // Read sequencing during the readout.
        if (issue) begin
            n_rd_vld  = 1'b1;
            n_rd_last = (r_rd_idx == r_last_idx);
            n_rd_idx  = r_rd_idx + CW'(1);
            if (r_rd_idx == r_last_idx) begin
                n_state = ST_RECV;
            end
        end else if (move) begin
            n_rd_vld = 1'b0;
        end
    end

    // Output register valid flag.
    always_comb begin
        n_out_vld = r_out_vld;
        if (move) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RECV;
            r_in_frame <= 1'b0;
            r_fill     <= '0;
            r_rd_idx   <= '0;
            r_last_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_last  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_frame <= n_in_frame;
            r_fill     <= n_fill;
            r_rd_idx   <= n_rd_idx;
            r_last_idx <= n_last_idx;
            r_rd_vld   <= n_rd_vld;
            r_rd_last  <= n_rd_last;
            r_out_vld  <= n_out_vld;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_byte <= i_mem_rdata;
            r_out_last <= r_rd_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

>>> design/delimited_frame_receiver.sv
// Delimited frame receiver. Received bytes enter on the slave stream at one
// item per cycle while input is not held off; bytes are dropped until the
// start delimiter, then stored in a FRAME_LEN-entry frame memory. A start
// delimiter restarts the frame, and a non-end byte arriving when FRAME_LEN-2
// bytes are held drops the frame. When the end delimiter arrives, the stored
// frame of n bytes (delimiters included, 2 to FRAME_LEN-1) leaves on the
// master stream, tlast on the closing delimiter. The single memory read port
// streams the frame out at one item per cycle while the output takes items,
// so input is held off from the closing delimiter until the read of the last
// byte is issued, and longer while the output stalls. The first frame byte
// passes from the readout state through the memory read register and the
// output register. The last two bytes may still wait in the read and output
// registers while new input is taken. Delimiters are set through the APB
// port: start at 0x0, end at 0x4.
module delimited_frame_receiver
    import dfr_pkg::*;
#(
    parameter int FRAME_LEN = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port.
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [2:0]        i_paddr,
    input  logic [CFG_W-1:0]  i_pwdata,
    output logic [CFG_W-1:0]  o_prdata,
    output logic              o_pready,
    // Received bytes.
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [BYTE_W-1:0] i_s_axis_tdata,   // [7:0] rx_byte
    // Frame bytes.
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [BYTE_W-1:0] o_m_axis_tdata,   // [7:0] frame_byte
    output logic              o_m_axis_tlast    // frame_last
);

    localparam int CW = $clog2(FRAME_LEN);

    logic [BYTE_W-1:0] r_start_delim;
    logic [BYTE_W-1:0] r_end_delim;
    t_delims           delims;
    t_reg_idx          reg_idx;
    logic              cfg_wr;

    logic              mem_we;
    logic [CW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [CW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    // Register file on the APB port.
    assign o_pready = 1'b1;
    assign reg_idx  = t_reg_idx'(i_paddr[2]);
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= DEF_START_DELIM;
            r_end_delim   <= DEF_END_DELIM;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_START_DELIM: r_start_delim <= i_pwdata[BYTE_W-1:0];
                REG_END_DELIM:   r_end_delim   <= i_pwdata[BYTE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (reg_idx)
            REG_START_DELIM: o_prdata[BYTE_W-1:0] = r_start_delim;
            REG_END_DELIM:   o_prdata[BYTE_W-1:0] = r_end_delim;
            default:         o_prdata = '0;
        endcase
    end

    assign delims.start_d = r_start_delim;
    assign delims.end_d   = r_end_delim;

    // Frame controller.
    dfr_ctrl #(
        .FRAME_LEN (FRAME_LEN),
        .CW        (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_delims    (delims),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_byte   (i_s_axis_tdata),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_byte  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Frame memory.
    dfr_store #(
        .DEPTH (FRAME_LEN),
        .AW    (CW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

>>> design/dfr_checker.sv
// Port-level checks of the delimited frame receiver, bound to the top level.
// Depends on delimited_frame_receiver_defines.svh for the assertion macros.
`include "delimited_frame_receiver_defines.svh"

module dfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic [31:0] i_prdata,
    input logic        i_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  i_m_axis_tdata,
    input logic        i_m_axis_tlast
);

    // Reset leaves no frame byte on offer.
    `DFR_ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !i_m_axis_tvalid)

    // A stalled frame byte keeps its value and its last marker.
    `DFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tlast))

    // Delimiter registers are one byte wide; the upper read bits stay zero.
    `DFR_ASSERT_NOW(a_prdata_upper_zero, i_clk, i_rst_n, 1'b1, i_prdata[31:8] == 24'h0)

endmodule

bind delimited_frame_receiver dfr_checker u_dfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_prdata        (o_prdata),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

>>> tb/delimited_frame_receiver_checker.sv
// Scoreboard for the delimited frame receiver: follows the APB writes and both
// streams, predicts every frame byte and compares it with what leaves the block.
// Depends on dfr_pkg for the byte width, the register indexes and the reset delimiters.
`timescale 1ns / 1ps

module delimited_frame_receiver_checker
    import dfr_pkg::*;
#(
    parameter int FRAME_LEN = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port, observed only.
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [2:0]        i_paddr,
    input  logic [CFG_W-1:0]  i_pwdata,
    input  logic              i_pready,
    // Received byte stream.
    input  logic              i_rx_valid,
    input  logic              i_rx_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // Frame byte stream.
    input  logic              i_frame_valid,
    input  logic              i_frame_ready,
    input  logic [BYTE_W-1:0] i_frame_byte,
    input  logic              i_frame_last,
    // Status for the testbench top.
    output int                o_mismatches,
    output int                o_pending,
    output int                o_frames_done
);

    localparam int IDX_W      = $clog2(FRAME_LEN);
    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_frame_beat;

    // Shadow of the delimiter registers and of the frame collector.
    logic [BYTE_W-1:0] start_delim;
    logic [BYTE_W-1:0] end_delim;
    logic              in_frame;
    logic [IDX_W-1:0]  fill_idx;
    logic [BYTE_W-1:0] frame_mem [FRAME_LEN];
    t_frame_beat       expected_beats [$];
    t_reg_idx          reg_sel;

    function automatic void store_byte(input logic [BYTE_W-1:0] b);
        frame_mem[fill_idx] = b;
        fill_idx = fill_idx + 1'b1;
    endfunction

    // Advances the frame collector by one received byte and queues the frame
    // bytes that it releases.
    function automatic void absorb_rx_byte(input logic [BYTE_W-1:0] b);
        t_frame_beat beat;
        int          n_bytes;
        if (b == start_delim) begin
            // The start delimiter wins over everything, also when it equals the end.
            fill_idx = '0;
            store_byte(b);
            in_frame = 1'b1;
        end else if (in_frame) begin
            if (fill_idx == IDX_W'(FRAME_LEN - 2) && b != end_delim) begin
                // No room left for a closing delimiter: the frame is dropped.
                fill_idx = '0;
                in_frame = 1'b0;
            end else if (b == end_delim) begin
                store_byte(b);
                n_bytes = int'(fill_idx);
                for (int k = 0; k < n_bytes; k++) begin
                    beat.data = frame_mem[k];
                    beat.last = (k == n_bytes - 1);
                    expected_beats.push_back(beat);
                end
                fill_idx = '0;
                in_frame = 1'b0;
            end else begin
                store_byte(b);
            end
        end
    endfunction

    // Compares one frame byte that left the block with the oldest prediction.
    function automatic void check_frame_byte(input logic [BYTE_W-1:0] data,
                                             input logic last);
        t_frame_beat want;
        if (expected_beats.size() == 0) begin
            if (o_mismatches < REPORT_CAP) begin
                $display("%0t: unexpected frame byte: expected none, actual data %02h last %0b",
                         $time, data, last);
            end
            o_mismatches++;
        end else begin
            want = expected_beats.pop_front();
            if (data !== want.data || last !== want.last) begin
                if (o_mismatches < REPORT_CAP) begin
                    $display({"%0t: frame byte mismatch: expected data %02h last %0b, ",
                              "actual data %02h last %0b"},
                             $time, want.data, want.last, data, last);
                end
                o_mismatches++;
            end
            if (want.last) begin
                o_frames_done++;
            end
        end
    endfunction

    // Everything is sampled at the rising edge, before the edge's updates land.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_delim = DEF_START_DELIM;
            end_delim   = DEF_END_DELIM;
            in_frame    = 1'b0;
            fill_idx    = '0;
            expected_beats.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[1:0] == 2'b00) begin
                reg_sel = t_reg_idx'(i_paddr[2]);
                case (reg_sel)
                    REG_START_DELIM: start_delim = i_pwdata[BYTE_W-1:0];
                    REG_END_DELIM:   end_delim   = i_pwdata[BYTE_W-1:0];
                endcase
            end
            if (i_frame_valid && i_frame_ready) begin
                check_frame_byte(i_frame_byte, i_frame_last);
            end
            if (i_rx_valid && i_rx_ready) begin
                absorb_rx_byte(i_rx_byte);
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

>>> tb/delimited_frame_receiver_tb.sv
// Testbench top of the delimited frame receiver: drives received bytes, stalls the
// frame output and reprograms the delimiters; the checker module does the comparing.
// Depends on dfr_pkg, delimited_frame_receiver and delimited_frame_receiver_checker.
`timescale 1ns / 1ps

module delimited_frame_receiver_tb;
    import dfr_pkg::*;

    localparam int FRAME_LEN       = 16;
    localparam int MAX_PAYLOAD     = FRAME_LEN - 3;
    localparam int DRAIN_CYCLES    = 24;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Opening bytes: noise while idle, the shortest frame, a restarted frame and
    // a frame of the greatest length.
    localparam logic [BYTE_W-1:0] OPENING_BYTES [25] = '{
        8'h00, 8'hFF, DEF_END_DELIM,
        DEF_START_DELIM, DEF_END_DELIM,
        DEF_START_DELIM, 8'h01, DEF_START_DELIM, 8'h80, DEF_END_DELIM,
        DEF_START_DELIM, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F,
        8'hFE, 8'h3D, 8'h3B, 8'h0F, 8'hF0, 8'h3F, DEF_END_DELIM
    };

    typedef enum {RX_ALWAYS, RX_EAGER, RX_SLOW, RX_PATTERN} t_rx_pace;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [CFG_W-1:0]  pwdata;
    logic [CFG_W-1:0]  prdata;
    logic              pready;
    logic              rx_valid;
    logic              rx_ready;
    logic [BYTE_W-1:0] rx_data;
    logic              frame_valid;
    logic              frame_ready;
    logic [BYTE_W-1:0] frame_data;
    logic              frame_last;

    int                mismatches;
    int                bytes_pending;
    int                frames_done;
    int unsigned       bytes_sent = 0;
    int unsigned       burst_left = 0;
    bit                tx_bursty = 1'b1;
    bit                hold_off_req = 1'b0;
    t_rx_pace          rx_pace = RX_EAGER;
    logic [BYTE_W-1:0] cur_start = DEF_START_DELIM;
    logic [BYTE_W-1:0] cur_end = DEF_END_DELIM;

    delimited_frame_receiver #(
        .FRAME_LEN (FRAME_LEN)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready),
        .i_s_axis_tvalid (rx_valid),
        .o_s_axis_tready (rx_ready),
        .i_s_axis_tdata  (rx_data),
        .o_m_axis_tvalid (frame_valid),
        .i_m_axis_tready (frame_ready),
        .o_m_axis_tdata  (frame_data),
        .o_m_axis_tlast  (frame_last)
    );

    delimited_frame_receiver_checker #(
        .FRAME_LEN (FRAME_LEN)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .i_rx_valid    (rx_valid),
        .i_rx_ready    (rx_ready),
        .i_rx_byte     (rx_data),
        .i_frame_valid (frame_valid),
        .i_frame_ready (frame_ready),
        .i_frame_byte  (frame_data),
        .i_frame_last  (frame_last),
        .o_mismatches  (mismatches),
        .o_pending     (bytes_pending),
        .o_frames_done (frames_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Output side: a pace chosen per phase, and one long hold-off on request.
    initial begin
        int unsigned tick;
        tick = 0;
        frame_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                frame_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                case (rx_pace)
                    RX_ALWAYS:  frame_ready <= 1'b1;
                    RX_EAGER:   frame_ready <= ($urandom_range(0, 3) != 0);
                    RX_SLOW:    frame_ready <= ($urandom_range(0, 9) < 3);
                    RX_PATTERN: frame_ready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    // Ends the run when no item has moved on either stream for too long.
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((rx_valid && rx_ready) || (frame_valid && frame_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Offers one byte and returns at the edge that accepts it; in burst mode a
    // random gap comes before each new burst.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                  : $urandom_range(0, 3);
                burst_left = $urandom_range(1, 12);
                if (gap != 0) begin
                    rx_valid <= 1'b0;
                    rx_data  <= 8'($urandom);
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        rx_valid <= 1'b1;
        rx_data  <= b;
        do @(posedge i_clk); while (!rx_ready);
        bytes_sent++;
    endtask

    // A byte that is neither delimiter.
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do b = 8'($urandom); while (b == cur_start || b == cur_end);
        return b;
    endfunction

    // Payload byte: now and then any value, a stray delimiter included.
    function automatic logic [BYTE_W-1:0] payload_byte();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : plain_byte();
    endfunction

    task automatic send_frame(input int unsigned payload_len);
        send_byte(cur_start);
        repeat (payload_len) send_byte(payload_byte());
        send_byte(cur_end);
    endtask

    // Fills the frame store and then sends a byte that is not the end delimiter.
    task automatic send_overflow();
        send_byte(cur_start);
        repeat (MAX_PAYLOAD + 1) send_byte(plain_byte());
    endtask

    // Mostly well-formed frames, with noise, restarts and overflows between them.
    task automatic run_random(input int unsigned budget);
        int unsigned target;
        int unsigned roll;
        target = bytes_sent + budget;
        while (bytes_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 62) begin
                send_frame($urandom_range(0, MAX_PAYLOAD));
            end else if (roll < 74) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (roll < 88) begin
                send_byte(cur_start);
                repeat ($urandom_range(0, 5)) send_byte(plain_byte());
                send_frame($urandom_range(0, MAX_PAYLOAD));
            end else begin
                send_overflow();
            end
        end
    endtask

    // Stops offering, waits for every predicted frame byte, then lets the
    // block settle.
    task automatic wait_drained();
        rx_valid <= 1'b0;
        do @(posedge i_clk); while (bytes_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & 32'hFFFF_FF00) | {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_START_DELIM: cur_start = value;
            REG_END_DELIM:   cur_end   = value;
        endcase
    endtask

    task automatic set_delimiters(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        write_reg(REG_START_DELIM, s);
        write_reg(REG_END_DELIM, e);
    endtask

    initial begin
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] e;
        i_rst_n  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rx_valid <= 1'b0;
        rx_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset delimiters: opening cases, then a pause until the output is empty.
        rx_pace = RX_EAGER;
        foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
        wait_drained();
        send_overflow();
        run_random(55);
        wait_drained();

        // Lowest start, highest end, output stalling on a fixed pattern.
        rx_pace = RX_PATTERN;
        set_delimiters(8'h00, 8'hFF);
        run_random(55);
        wait_drained();

        // Reversed extremes with no idling on either side.
        tx_bursty = 1'b0;
        rx_pace   = RX_ALWAYS;
        set_delimiters(8'hFF, 8'h00);
        run_random(45);
        wait_drained();

        // Equal delimiters: every delimiter restarts, so no frame ever closes.
        tx_bursty = 1'b1;
        rx_pace   = RX_EAGER;
        s = 8'($urandom);
        set_delimiters(s, s);
        run_random(30);
        wait_drained();

        // Random delimiters; the output holds off for a long stretch while
        // bytes keep coming, so the block has to stall its input.
        tx_bursty = 1'b0;
        s = 8'($urandom);
        do e = 8'($urandom); while (e == s);
        set_delimiters(s, e);
        hold_off_req = 1'b1;
        send_frame(MAX_PAYLOAD);
        run_random(55);
        wait_drained();

        // Back to the reset delimiters with a slow receiver.
        tx_bursty = 1'b1;
        rx_pace   = RX_SLOW;
        set_delimiters(DEF_START_DELIM, DEF_END_DELIM);
        run_random(45);
        wait_drained();

        $display("Drove %0d received bytes under six delimiter settings, equal ones included.",
                 bytes_sent);
        $display("%0d complete frames came out and were compared byte by byte.", frames_done);
        if (bytes_pending != 0) begin
            $display("%0t: %0d predicted frame bytes never came out", $time, bytes_pending);
        end
        if (mismatches == 0 && bytes_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/dfr_pkg.sv
design/dfr_store.sv
design/dfr_ctrl.sv
design/delimited_frame_receiver.sv
design/dfr_checker.sv
tb/delimited_frame_receiver_checker.sv
tb/delimited_frame_receiver_tb.sv
